### src/hcfp_pkg.sv
package hcfp_pkg;

  // character codes used by the parser
  localparam logic [7:0] CHAR_T      = 8'h54;
  localparam logic [7:0] CHAR_V      = 8'h56;
  localparam logic [7:0] CHAR_S      = 8'h53;
  localparam logic [7:0] CHAR_U      = 8'h55;
  localparam logic [7:0] CHAR_Z      = 8'h5A;
  localparam logic [7:0] CHAR_LBRACE = 8'h7B;
  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_SEMI   = 8'h3B;

  // message positions
  localparam logic [1:0] POS_CSUM_HI = 2'd0;
  localparam logic [1:0] POS_CSUM_LO = 2'd1;
  localparam logic [1:0] POS_LETTER  = 2'd2;
  localparam logic [1:0] POS_PAYLOAD = 2'd3;

  // status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_CHECKSUM  = 2'd1;
  localparam logic [1:0] STATUS_PARSE_ERR = 2'd2;
  localparam logic [1:0] STATUS_UNKNOWN   = 2'd3;

  localparam int unsigned RESULT_W = 112;

  // one result transaction
  typedef struct packed {
    logic        power_on;
    logic        clear_speeds;
    logic        reset_servo;
    logic        restart_timeout;
    logic [31:0] value_third;
    logic [31:0] value_second;
    logic [31:0] value_first;
    logic [1:0]  values_parsed;
    logic [7:0]  command;
    logic [1:0]  status;
  } result_t;

  // hex digit decode: {is_hex, digit}, digit zero when not hex
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

### src/hcfp_char_stage.sv
module hcfp_char_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_last,
  input  logic       advance,
  output logic       item_valid,
  output logic [7:0] item_char,
  output logic       item_last
);

  // stage is free when empty or when its item moves on this cycle
  assign in_ready = !item_valid || advance;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_char <= in_char;
      item_last <= in_last;
    end
  end

endmodule

### src/hcfp_parse_core.sv
module hcfp_parse_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic [7:0]           char_code,
  input  logic                 last_char,
  output hcfp_pkg::result_t    res
);

  logic [1:0]  char_position, char_position_next;
  logic [7:0]  received_checksum, received_checksum_next;
  logic [7:0]  running_sum, running_sum_next;
  logic        checksum_malformed, checksum_malformed_next;
  logic [7:0]  command_letter, command_letter_next;
  logic [31:0] hex_accumulator, hex_accumulator_next;
  logic        digit_seen, digit_seen_next;
  logic        field_done, field_done_next;
  logic [1:0]  field_number, field_number_next;
  logic        parse_failed, parse_failed_next;
  logic [31:0] captured_first, captured_first_next;
  logic [31:0] captured_second, captured_second_next;

  logic [4:0]  hex;
  logic        is_one, is_three, frame_bad;
  logic [1:0]  count, need, vp;
  logic [31:0] v0, v1, v2;

  assign hex = hcfp_pkg::hex_decode(char_code);

  // per-character state update
  always_comb begin
    char_position_next      = char_position;
    received_checksum_next  = received_checksum;
    running_sum_next        = running_sum;
    checksum_malformed_next = checksum_malformed;
    command_letter_next     = command_letter;
    hex_accumulator_next    = hex_accumulator;
    digit_seen_next         = digit_seen;
    field_done_next         = field_done;
    field_number_next       = field_number;
    parse_failed_next       = parse_failed;
    captured_first_next     = captured_first;
    captured_second_next    = captured_second;
    unique case (char_position)
      hcfp_pkg::POS_CSUM_HI: begin
        if (!hex[4]) checksum_malformed_next = 1'b1;
        received_checksum_next = {hex[3:0], 4'h0};
        char_position_next     = hcfp_pkg::POS_CSUM_LO;
      end
      hcfp_pkg::POS_CSUM_LO: begin
        if (!hex[4]) checksum_malformed_next = 1'b1;
        received_checksum_next = {received_checksum[7:4], hex[3:0]};
        char_position_next     = hcfp_pkg::POS_LETTER;
      end
      hcfp_pkg::POS_LETTER: begin
        command_letter_next = char_code;
        running_sum_next    = char_code;
        char_position_next  = hcfp_pkg::POS_PAYLOAD;
      end
      default: begin
        running_sum_next = running_sum + char_code;
        // payload field parsing
        if (!parse_failed) begin
          if (char_code == hcfp_pkg::CHAR_SEMI) begin
            if (field_number < 2'd2) begin
              if (!digit_seen) begin
                parse_failed_next = 1'b1;
              end else begin
                if (field_number[0]) captured_second_next = hex_accumulator;
                else                 captured_first_next  = hex_accumulator;
                field_number_next    = field_number + 2'd1;
                hex_accumulator_next = 32'd0;
                digit_seen_next      = 1'b0;
                field_done_next      = 1'b0;
              end
            end else begin
              field_done_next = 1'b1;
            end
          end else if (!field_done) begin
            if (hex[4]) begin
              hex_accumulator_next = {hex_accumulator[27:0], hex[3:0]};
              digit_seen_next      = 1'b1;
            end else begin
              field_done_next = 1'b1;
            end
          end
        end
      end
    endcase
  end

  // result from the post-update state
  always_comb begin
    frame_bad = (char_position_next != hcfp_pkg::POS_PAYLOAD) || checksum_malformed_next ||
                (running_sum_next != received_checksum_next);
    is_one    = (command_letter_next == hcfp_pkg::CHAR_T) ||
                (command_letter_next == hcfp_pkg::CHAR_V) ||
                (command_letter_next == hcfp_pkg::CHAR_S) ||
                (command_letter_next == hcfp_pkg::CHAR_U);
    is_three  = (command_letter_next == hcfp_pkg::CHAR_LBRACE) ||
                (command_letter_next == hcfp_pkg::CHAR_LPAREN) ||
                (command_letter_next == hcfp_pkg::CHAR_Z);
    count = field_number_next + {1'b0, (!parse_failed_next && digit_seen_next)};
    need  = is_three ? 2'd3 : 2'd1;
    vp    = (count < need) ? count : need;
    v0 = (vp > 2'd0) ? ((field_number_next > 2'd0) ? captured_first_next  : hex_accumulator_next)
                     : 32'd0;
    v1 = (vp > 2'd1) ? ((field_number_next > 2'd1) ? captured_second_next : hex_accumulator_next)
                     : 32'd0;
    v2 = (vp > 2'd2) ? hex_accumulator_next : 32'd0;

    res = '0;
    res.command = command_letter_next;
    if (frame_bad) begin
      res.status = hcfp_pkg::STATUS_CHECKSUM;
    end else begin
      if (count == 2'd0)          res.status = hcfp_pkg::STATUS_PARSE_ERR;
      else if (!is_one && !is_three) res.status = hcfp_pkg::STATUS_UNKNOWN;
      else if (vp < need)         res.status = hcfp_pkg::STATUS_PARSE_ERR;
      else                        res.status = hcfp_pkg::STATUS_OK;
      res.values_parsed = vp;
      res.value_first   = v0;
      res.value_second  = v1;
      res.value_third   = v2;
      if (res.status == hcfp_pkg::STATUS_OK) begin
        res.restart_timeout = (command_letter_next == hcfp_pkg::CHAR_T) ||
                              (command_letter_next == hcfp_pkg::CHAR_V);
        res.reset_servo     = (command_letter_next == hcfp_pkg::CHAR_S) ||
                              (command_letter_next == hcfp_pkg::CHAR_Z);
        res.clear_speeds    = (command_letter_next == hcfp_pkg::CHAR_U) ||
                              (command_letter_next == hcfp_pkg::CHAR_Z);
        res.power_on        = (command_letter_next == hcfp_pkg::CHAR_U) && (v0[30:0] != 31'd0);
      end
    end
  end

  // message state, cleared at every message end
  always_ff @(posedge clk) begin
    if (rst) begin
      char_position      <= hcfp_pkg::POS_CSUM_HI;
      received_checksum  <= 8'd0;
      running_sum        <= 8'd0;
      checksum_malformed <= 1'b0;
      command_letter     <= 8'd0;
      hex_accumulator    <= 32'd0;
      digit_seen         <= 1'b0;
      field_done         <= 1'b0;
      field_number       <= 2'd0;
      parse_failed       <= 1'b0;
    end else if (advance) begin
      if (last_char) begin
        char_position      <= hcfp_pkg::POS_CSUM_HI;
        received_checksum  <= 8'd0;
        running_sum        <= 8'd0;
        checksum_malformed <= 1'b0;
        command_letter     <= 8'd0;
        hex_accumulator    <= 32'd0;
        digit_seen         <= 1'b0;
        field_done         <= 1'b0;
        field_number       <= 2'd0;
        parse_failed       <= 1'b0;
      end else begin
        char_position      <= char_position_next;
        received_checksum  <= received_checksum_next;
        running_sum        <= running_sum_next;
        checksum_malformed <= checksum_malformed_next;
        command_letter     <= command_letter_next;
        hex_accumulator    <= hex_accumulator_next;
        digit_seen         <= digit_seen_next;
        field_done         <= field_done_next;
        field_number       <= field_number_next;
        parse_failed       <= parse_failed_next;
      end
    end
  end

  // captured values, only read once written in the current message
  always_ff @(posedge clk) begin
    if (advance) begin
      captured_first  <= captured_first_next;
      captured_second <= captured_second_next;
    end
  end

endmodule

### src/hcfp_result_reg.sv
module hcfp_result_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  hcfp_pkg::result_t res_in,
  output logic              slot_free,
  output logic              out_valid,
  input  logic              out_ready,
  output hcfp_pkg::result_t res_out
);

  // a new result may enter when empty or when the held one leaves now
  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && slot_free) begin
      res_out <= res_in;
    end
  end

endmodule

### src/hex_command_frame_parser_unit.sv
// a message result is loaded into the result register when its last character leaves the input register
// throughput: one character per cycle, unless a last character waits for a busy result register;
// the parse core update between the input register and the result register is combinational
// reset (rst, synchronous, active high) empties both registers and clears the message state
module hex_command_frame_parser_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] char_code
  input  logic                            s_axis_tlast,  // last_char
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [1:0] status, [9:2] command, [11:10] values_parsed, [43:12] value_first,
  // [75:44] value_second, [107:76] value_third, [108] restart_timeout,
  // [109] reset_servo, [110] clear_speeds, [111] power_on
  output logic [hcfp_pkg::RESULT_W-1:0]   m_axis_tdata
);

  logic              item_valid;
  logic [7:0]        item_char;
  logic              item_last;
  logic              advance;
  logic              slot_free;
  hcfp_pkg::result_t core_res;
  hcfp_pkg::result_t out_res;

  // an item moves on unless it ends a message and the result slot is busy
  assign advance = item_valid && (!item_last || slot_free);

  hcfp_char_stage u_char_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_char    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .advance    (advance),
    .item_valid (item_valid),
    .item_char  (item_char),
    .item_last  (item_last)
  );

  hcfp_parse_core u_parse_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .char_code (item_char),
    .last_char (item_last),
    .res       (core_res)
  );

  hcfp_result_reg u_result_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && item_last),
    .res_in    (core_res),
    .slot_free (slot_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .res_out   (out_res)
  );

  assign m_axis_tdata = out_res;

endmodule
